// ----- rtl/core/mcr_pkg.sv -----
// Shared types and constants for the midpoint circle rasterizer.
// Used by the front end, the job queue, the point emitter and the top level.
package mcr_pkg;

    localparam int RADIUS_MAX_DEF = 1023;

    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 10;
    localparam int STEP_W   = 11;
    localparam int DEC_W    = 16;
    localparam int POINT_W  = 17;

    localparam logic [DEC_W-1:0] DEC_INIT  = 16'd5;
    localparam logic [DEC_W-1:0] EAST_BIAS = 16'd12;  // 4 * 3
    localparam logic [DEC_W-1:0] SE_BIAS   = 16'd20;  // 4 * 5

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    localparam logic [2:0] POLES_LAST   = 3'd3;
    localparam logic [2:0] OCTANTS_LAST = 3'd7;

    typedef enum logic {
        KIND_POLES   = 1'b0,
        KIND_OCTANTS = 1'b1
    } t_kind;

    // One unit of drawing work handed from the front end to the emitter.
    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [STEP_W-1:0]         x;
        logic [STEP_W-1:0]         y;
        t_kind                     kind;
        logic                      finished;
    } t_job;

endpackage

// ----- rtl/core/midpoint_circle_rasterizer.sv -----
// Top level of the midpoint circle rasterizer: front end, job queue, point emitter.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
//
//   channel   direction  handshake          payload
//   items     in         push / full        i_action, i_center_x, i_center_y, i_radius
//   points    out        empty / pop        o_point_x, o_point_y, o_last, o_finished
//
// Items are taken every cycle while the job queue has room; the front end updates the
// circle state in the cycle of acceptance. The emitter sends one point per cycle while the
// consumer keeps taking them, so a start item yields four points and a step item eight;
// the emitter sets the sustained rate. A step item with no circle in progress is accepted
// and produces nothing. Reset is synchronous and active low and clears the circle state,
// the queue and the result slot. The two sides stall apart: a held result blocks only
// the emitter, while the queue keeps absorbing items.
module midpoint_circle_rasterizer #(
    parameter int RADIUS_MAX = mcr_pkg::RADIUS_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic                                i_action,
    input  logic signed [mcr_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [mcr_pkg::COORD_W-1:0]  i_center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]        i_radius,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [mcr_pkg::POINT_W-1:0]  o_point_x,
    output logic signed [mcr_pkg::POINT_W-1:0]  o_point_y,
    output logic                                o_last,
    output logic                                o_finished
);

    logic          accept;
    logic          q_push, q_pop, q_full, q_empty;
    mcr_pkg::t_job q_job, q_head;
    logic          out_valid;

    // An item enters only when the queue can take whatever job it produces.
    assign accept = push && !q_full;
    assign full   = q_full;
    assign empty  = !out_valid;

    mcr_front #(
        .RADIUS_MAX (RADIUS_MAX)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_push     (q_push),
        .o_job      (q_job)
    );

    mcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    // The emitter works through the oldest job and holds each point in its
    // output register until the consumer takes it.
    mcr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (!q_empty),
        .i_head       (q_head),
        .o_pop_job    (q_pop),
        .i_take       (pop),
        .o_valid      (out_valid),
        .o_point_x    (o_point_x),
        .o_point_y    (o_point_y),
        .o_last       (o_last),
        .o_finished   (o_finished)
    );

    // A job is never offered to a full queue.
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("job pushed into a full queue");

    // A start item always leaves work queued behind it.
    a_start_queues_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_action == mcr_pkg::ACT_START)) |=> !q_empty)
        else $error("start item produced no queued job");

    // A job leaves the queue only as its final point lands in the result slot.
    a_retire_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_last && !empty))
        else $error("job retired without its final point");

endmodule

// ----- rtl/core/mcr_front.sv -----
// Front end: accepts items, keeps the circle state and issues drawing jobs.
// Depends on mcr_pkg.
module mcr_front #(
    parameter int RADIUS_MAX = mcr_pkg::RADIUS_MAX_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_accept,
    input  logic                                i_action,
    input  logic signed [mcr_pkg::COORD_W-1:0]  i_center_x,
    input  logic signed [mcr_pkg::COORD_W-1:0]  i_center_y,
    input  logic [mcr_pkg::RADIUS_W-1:0]        i_radius,
    output logic                                o_push,
    output mcr_pkg::t_job                       o_job
);

    logic [mcr_pkg::STEP_W-1:0]         r_step_x, n_step_x;
    logic [mcr_pkg::STEP_W-1:0]         r_step_y, n_step_y;
    logic [mcr_pkg::DEC_W-1:0]          r_decision, n_decision;
    logic signed [mcr_pkg::COORD_W-1:0] r_cx, n_cx;
    logic signed [mcr_pkg::COORD_W-1:0] r_cy, n_cy;
    logic                               r_active, n_active;

    logic [mcr_pkg::RADIUS_W-1:0] radius_sat;
    logic signed [mcr_pkg::STEP_W:0] diff;
    logic [mcr_pkg::DEC_W-1:0]    delta;
    logic                         go_se;

    always_comb begin
        if ({7'b0, i_radius} > 17'(RADIUS_MAX)) begin
            radius_sat = mcr_pkg::RADIUS_W'(RADIUS_MAX);
        end else begin
            radius_sat = i_radius;
        end

        go_se = ($signed(r_decision) > 0);
        diff  = $signed({1'b0, r_step_x}) - $signed({1'b0, r_step_y});
        if (go_se) begin
            delta = {{1{diff[mcr_pkg::STEP_W]}}, diff, 3'b000} + mcr_pkg::SE_BIAS;
        end else begin
            delta = {2'b00, r_step_x, 3'b000} + mcr_pkg::EAST_BIAS;
        end

        n_step_x   = r_step_x;
        n_step_y   = r_step_y;
        n_decision = r_decision;
        n_cx       = r_cx;
        n_cy       = r_cy;
        n_active   = r_active;
        o_push     = 1'b0;
        o_job.kind = mcr_pkg::KIND_POLES;

        if (i_accept) begin
            if (i_action == mcr_pkg::ACT_START) begin
                n_cx       = i_center_x;
                n_cy       = i_center_y;
                n_step_x   = '0;
                n_step_y   = {1'b0, radius_sat};
                n_decision = mcr_pkg::DEC_INIT - {4'b0000, radius_sat, 2'b00};
                n_active   = (radius_sat != '0);
                o_push     = 1'b1;
                o_job.kind = mcr_pkg::KIND_POLES;
            end else if (r_active) begin
                n_step_x   = r_step_x + 1'b1;
                n_step_y   = go_se ? (r_step_y - 1'b1) : r_step_y;
                n_decision = r_decision + delta;
                n_active   = (n_step_y > n_step_x);
                o_push     = 1'b1;
                o_job.kind = mcr_pkg::KIND_OCTANTS;
            end
        end

        o_job.cx       = n_cx;
        o_job.cy       = n_cy;
        o_job.x        = n_step_x;
        o_job.y        = n_step_y;
        o_job.finished = !n_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_x   <= '0;
            r_step_y   <= '0;
            r_decision <= '0;
            r_cx       <= '0;
            r_cy       <= '0;
            r_active   <= 1'b0;
        end else begin
            r_step_x   <= n_step_x;
            r_step_y   <= n_step_y;
            r_decision <= n_decision;
            r_cx       <= n_cx;
            r_cy       <= n_cy;
            r_active   <= n_active;
        end
    end

endmodule

// ----- rtl/core/mcr_queue.sv -----
// Short job queue between the front end and the point emitter.
// Depends on mcr_pkg for the job type and depth.
module mcr_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mcr_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output mcr_pkg::t_job o_head
);

    mcr_pkg::t_job r_mem [mcr_pkg::QUEUE_DEPTH];
    logic [mcr_pkg::QPTR_W-1:0] r_wr, r_rd;
    logic [mcr_pkg::QCNT_W-1:0] r_count;

    logic do_push, do_pop;

    assign o_full  = (r_count == mcr_pkg::QCNT_W'(mcr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/mcr_back.sv -----
// Point emitter: expands one job into four pole points or eight mirrored points.
// Depends on mcr_pkg; holds the registered result slot that drives the top-level outputs.
module mcr_back (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_head_valid,
    input  mcr_pkg::t_job                             i_head,
    output logic                                      o_pop_job,
    input  logic                                      i_take,
    output logic                                      o_valid,
    output logic signed [mcr_pkg::POINT_W-1:0]        o_point_x,
    output logic signed [mcr_pkg::POINT_W-1:0]        o_point_y,
    output logic                                      o_last,
    output logic                                      o_finished
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic signed [mcr_pkg::POINT_W-1:0] r_px, r_py;
    logic       r_last, r_fin;

    logic signed [mcr_pkg::STEP_W:0] px, nx, py, ny, dx, dy;
    logic [2:0] last_idx;
    logic       advance, is_last;
    logic signed [mcr_pkg::POINT_W-1:0] pt_x, pt_y;

    always_comb begin
        px = $signed({1'b0, i_head.x});
        py = $signed({1'b0, i_head.y});
        nx = -px;
        ny = -py;
        dx = '0;
        dy = '0;
        if (i_head.kind == mcr_pkg::KIND_POLES) begin
            last_idx = mcr_pkg::POLES_LAST;
            case (r_idx[1:0])
                2'd0:    begin dx = '0; dy = py; end
                2'd1:    begin dx = ny; dy = '0; end
                2'd2:    begin dx = '0; dy = ny; end
                default: begin dx = py; dy = '0; end
            endcase
        end else begin
            last_idx = mcr_pkg::OCTANTS_LAST;
            case (r_idx)
                3'd0:    begin dx = py; dy = px; end
                3'd1:    begin dx = px; dy = py; end
                3'd2:    begin dx = nx; dy = py; end
                3'd3:    begin dx = ny; dy = px; end
                3'd4:    begin dx = ny; dy = nx; end
                3'd5:    begin dx = nx; dy = ny; end
                3'd6:    begin dx = px; dy = ny; end
                default: begin dx = py; dy = nx; end
            endcase
        end
        pt_x = {i_head.cx[mcr_pkg::COORD_W-1], i_head.cx}
             + {{(mcr_pkg::POINT_W-mcr_pkg::STEP_W-1){dx[mcr_pkg::STEP_W]}}, dx};
        pt_y = {i_head.cy[mcr_pkg::COORD_W-1], i_head.cy}
             + {{(mcr_pkg::POINT_W-mcr_pkg::STEP_W-1){dy[mcr_pkg::STEP_W]}}, dy};
        is_last   = (r_idx == last_idx);
        advance   = i_head_valid && (!r_valid || i_take);
        o_pop_job = advance && is_last;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_px   <= pt_x;
            r_py   <= pt_y;
            r_last <= is_last;
            r_fin  <= i_head.finished;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_idx   <= is_last ? 3'd0 : (r_idx + 1'b1);
                r_valid <= 1'b1;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_point_x  = r_px;
    assign o_point_y  = r_py;
    assign o_last     = r_last;
    assign o_finished = r_fin;

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the midpoint circle rasterizer top level.
// Depends on mcr_pkg and midpoint_circle_rasterizer, and through it on mcr_front, mcr_queue and mcr_back.
module tb;

    // Decision arithmetic of the midpoint rule, with the decision scaled by four.
    localparam int DEC_BASE     = 5;
    localparam int DEC_SCALE    = 4;
    localparam int EAST_OFFSET  = 3;
    localparam int SE_OFFSET    = 5;
    localparam int RADIUS_LIMIT = mcr_pkg::RADIUS_MAX_DEF;

    localparam int ITEM_TARGET  = 460;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_MAX   = 10;

    // One input item as it appears on the ports.
    typedef struct packed {
        logic                               action;
        logic signed [mcr_pkg::COORD_W-1:0] cx;
        logic signed [mcr_pkg::COORD_W-1:0] cy;
        logic [mcr_pkg::RADIUS_W-1:0]       radius;
    } t_circle_cmd;

    // One plotted pixel as it appears on the result ports.
    typedef struct packed {
        logic signed [mcr_pkg::POINT_W-1:0] px;
        logic signed [mcr_pkg::POINT_W-1:0] py;
        logic                               last;
        logic                               finished;
    } t_pixel;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               push = 1'b0;
    logic                               full;
    logic                               i_action = 1'b0;
    logic signed [mcr_pkg::COORD_W-1:0] i_center_x = '0;
    logic signed [mcr_pkg::COORD_W-1:0] i_center_y = '0;
    logic [mcr_pkg::RADIUS_W-1:0]       i_radius = '0;
    logic                               empty;
    logic                               pop = 1'b0;
    logic signed [mcr_pkg::POINT_W-1:0] o_point_x;
    logic signed [mcr_pkg::POINT_W-1:0] o_point_y;
    logic                               o_last;
    logic                               o_finished;

    midpoint_circle_rasterizer u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_action   (i_action),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .empty      (empty),
        .pop        (pop),
        .o_point_x  (o_point_x),
        .o_point_y  (o_point_y),
        .o_last     (o_last),
        .o_finished (o_finished)
    );

    always #1 i_clk = ~i_clk;

    // Items waiting to be offered, and pixels predicted but not yet seen.
    t_circle_cmd pending_cmds[$];
    t_pixel      expected_pixels[$];

    // Shadow of the circle state inside the block.
    int pen_x;
    int pen_y;
    int err_term;
    int org_x;
    int org_y;
    bit drawing;

    int total_cmds;
    int useful_cmds;
    int n_accepted;
    int n_starts;
    int n_steps;
    int n_circles;
    int n_pixels;
    int n_errors;
    int cycle_count;
    int hold_left;
    bit hold_done;

    t_circle_cmd offered_cmd;
    t_circle_cmd next_cmd;
    t_pixel      seen_pixel;
    t_pixel      want_pixel;

    // Apply one accepted item to the shadow state and queue the pixels it
    // should produce. A start gives the four poles, a live step gives the
    // eight mirrored octant points, and a step with no circle gives nothing.
    task automatic plot_cmd(input t_circle_cmd cmd);
        int     ptx[8];
        int     pty[8];
        int     n;
        int     r;
        t_pixel pix;
        n = 0;
        if (cmd.action == mcr_pkg::ACT_START) begin
            r = cmd.radius;
            if (r > RADIUS_LIMIT) begin
                r = RADIUS_LIMIT;
            end
            org_x    = cmd.cx;
            org_y    = cmd.cy;
            pen_x    = 0;
            pen_y    = r;
            err_term = DEC_BASE - DEC_SCALE * r;
            drawing  = pen_y > pen_x;
            ptx[0] = org_x;     pty[0] = org_y + r;
            ptx[1] = org_x - r; pty[1] = org_y;
            ptx[2] = org_x;     pty[2] = org_y - r;
            ptx[3] = org_x + r; pty[3] = org_y;
            n = 4;
            n_starts++;
        end else if (drawing) begin
            // The decision is updated from the coordinates before the move.
            if (err_term > 0) begin
                err_term += DEC_SCALE * (2 * (pen_x - pen_y) + SE_OFFSET);
                pen_x++;
                pen_y--;
            end else begin
                err_term += DEC_SCALE * (2 * pen_x + EAST_OFFSET);
                pen_x++;
            end
            drawing = pen_y > pen_x;
            ptx[0] = org_x + pen_y; pty[0] = org_y + pen_x;
            ptx[1] = org_x + pen_x; pty[1] = org_y + pen_y;
            ptx[2] = org_x - pen_x; pty[2] = org_y + pen_y;
            ptx[3] = org_x - pen_y; pty[3] = org_y + pen_x;
            ptx[4] = org_x - pen_y; pty[4] = org_y - pen_x;
            ptx[5] = org_x - pen_x; pty[5] = org_y - pen_y;
            ptx[6] = org_x + pen_x; pty[6] = org_y - pen_y;
            ptx[7] = org_x + pen_y; pty[7] = org_y - pen_x;
            n = 8;
            n_steps++;
        end
        for (int k = 0; k < n; k++) begin
            pix.px       = ptx[k][mcr_pkg::POINT_W-1:0];
            pix.py       = pty[k][mcr_pkg::POINT_W-1:0];
            pix.last     = (k == n - 1);
            pix.finished = !drawing;
            expected_pixels.push_back(pix);
        end
        if (n > 0 && !drawing) begin
            n_circles++;
        end
    endtask

    task automatic queue_cmd(input logic act, input logic [mcr_pkg::COORD_W-1:0] cx,
                             input logic [mcr_pkg::COORD_W-1:0] cy,
                             input logic [mcr_pkg::RADIUS_W-1:0] r);
        t_circle_cmd cmd;
        cmd.action = act;
        cmd.cx     = cx;
        cmd.cy     = cy;
        cmd.radius = r;
        pending_cmds.push_back(cmd);
    endtask

    // A start followed by a run of steps. The step items carry random fields,
    // which the block must ignore.
    task automatic add_circle(input logic [mcr_pkg::COORD_W-1:0] cx,
                              input logic [mcr_pkg::COORD_W-1:0] cy,
                              input logic [mcr_pkg::RADIUS_W-1:0] r, input int steps);
        queue_cmd(mcr_pkg::ACT_START, cx, cy, r);
        for (int k = 0; k < steps; k++) begin
            queue_cmd(mcr_pkg::ACT_STEP, mcr_pkg::COORD_W'($urandom()),
                      mcr_pkg::COORD_W'($urandom()), mcr_pkg::RADIUS_W'($urandom()));
        end
        useful_cmds += 1 + steps;
    endtask

    // Idle rates by phase: the sender idles lightly while the receiver idles
    // heavily, then the other way round, then neither idles.
    function automatic int sender_idle_pct();
        if (n_accepted < total_cmds / 3) begin
            return 33;
        end else if (n_accepted < (2 * total_cmds) / 3) begin
            return 88;
        end
        return 0;
    endfunction

    function automatic int receiver_idle_pct();
        if (n_accepted < total_cmds / 3) begin
            return 88;
        end else if (n_accepted < (2 * total_cmds) / 3) begin
            return 33;
        end
        return 0;
    endfunction

    // Driver: predicts each item at the edge where it is taken, holds an item
    // steady while the block is full, and otherwise offers the next one or
    // idles at random.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                plot_cmd(offered_cmd);
                n_accepted <= n_accepted + 1;
            end
            if (push && full) begin
                push <= 1'b1;
            end else if (pending_cmds.size() != 0 &&
                         $urandom_range(0, 99) >= sender_idle_pct()) begin
                next_cmd    = pending_cmds.pop_front();
                offered_cmd = next_cmd;
                push       <= 1'b1;
                i_action   <= next_cmd.action;
                i_center_x <= next_cmd.cx;
                i_center_y <= next_cmd.cy;
                i_radius   <= next_cmd.radius;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, armed once in the phase without idling, so the
    // sender keeps offering until the block backs up and raises full.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && total_cmds > 0 && n_accepted >= (3 * total_cmds) / 4) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: every pixel taken from the block is checked against the oldest
    // prediction, field by field.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                seen_pixel.px       = o_point_x;
                seen_pixel.py       = o_point_y;
                seen_pixel.last     = o_last;
                seen_pixel.finished = o_finished;
                n_pixels++;
                if (expected_pixels.size() == 0) begin
                    n_errors++;
                    if (n_errors <= REPORT_MAX) begin
                        $display("ERROR: pixel nothing predicted: x=%0d y=%0d last=%0b fin=%0b",
                                 seen_pixel.px, seen_pixel.py, seen_pixel.last,
                                 seen_pixel.finished);
                    end
                end else begin
                    want_pixel = expected_pixels.pop_front();
                    if (seen_pixel.px !== want_pixel.px || seen_pixel.py !== want_pixel.py ||
                        seen_pixel.last !== want_pixel.last ||
                        seen_pixel.finished !== want_pixel.finished) begin
                        n_errors++;
                        if (n_errors <= REPORT_MAX) begin
                            $display("ERROR: pixel %0d expected x=%0d y=%0d last=%0b fin=%0b",
                                     n_pixels, want_pixel.px, want_pixel.py, want_pixel.last,
                                     want_pixel.finished);
                            $display("       got      x=%0d y=%0d last=%0b fin=%0b",
                                     seen_pixel.px, seen_pixel.py, seen_pixel.last,
                                     seen_pixel.finished);
                        end
                    end
                end
            end
            pop <= (hold_left == 0) && ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d pixels still predicted",
                     cycle_count, expected_pixels.size());
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        int pick;
        int r;
        useful_cmds = 0;

        // Directed items. A step right after reset must give nothing. Then the
        // coordinate extremes with the largest radius, a zero radius that
        // finishes at once, radius one finishing in a single step, all-ones
        // centers, a circle dropped by a new start, and steps past the end of
        // a finished circle.
        queue_cmd(mcr_pkg::ACT_STEP, 16'h1234, 16'h8765, 10'h2AA);
        add_circle(16'h7FFF, 16'h8000, 10'd1023, 3);
        add_circle(16'h8000, 16'h7FFF, 10'd0, 1);
        add_circle(16'h0000, 16'h0000, 10'd1, 2);
        add_circle(16'hFFFF, 16'hFFFF, 10'd2, 3);
        add_circle(16'd100, -16'sd100, 10'd5, 1);
        add_circle(-16'sd5, 16'd7, 10'd3, 3);
        add_circle(16'h0001, 16'h0000, 10'd512, 2);

        // Random part: mostly complete small circles, some partial ones
        // with any radius, some medium circles, and a share of loose items.
        // The step count overshoots a little, so a few idle steps follow.
        while (useful_cmds < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                r = $urandom_range(0, 24);
                add_circle(mcr_pkg::COORD_W'($urandom()), mcr_pkg::COORD_W'($urandom()),
                           mcr_pkg::RADIUS_W'(r), (3 * r) / 4 + 1 + $urandom_range(0, 1));
            end else if (pick < 80) begin
                add_circle(mcr_pkg::COORD_W'($urandom()), mcr_pkg::COORD_W'($urandom()),
                           mcr_pkg::RADIUS_W'($urandom()), $urandom_range(0, 6));
            end else if (pick < 88) begin
                r = $urandom_range(25, 80);
                add_circle(mcr_pkg::COORD_W'($urandom()), mcr_pkg::COORD_W'($urandom()),
                           mcr_pkg::RADIUS_W'(r), (3 * r) / 4 + 1);
            end else begin
                queue_cmd(1'($urandom_range(0, 1)), mcr_pkg::COORD_W'($urandom()),
                          mcr_pkg::COORD_W'($urandom()), mcr_pkg::RADIUS_W'($urandom()));
                useful_cmds++;
            end
        end
        total_cmds = pending_cmds.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Let every item be taken, then every predicted pixel arrive, then
        // give the block time to show any stray pixel.
        while (pending_cmds.size() != 0 || push) begin
            @(posedge i_clk);
        end
        while (expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Run: %0d items taken (%0d starts, %0d live steps), %0d circles completed",
                 n_accepted, n_starts, n_steps, n_circles);
        $display("     %0d pixels checked in %0d cycles, %0d mismatches",
                 n_pixels, cycle_count, n_errors);
        if (n_errors == 0 && expected_pixels.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
